// ===== hw/rtl/two_level_writeback_cache_defines.svh =====
// Assertion macros shared by the cache RTL.
`ifndef TWO_LEVEL_WRITEBACK_CACHE_DEFINES_SVH
`define TWO_LEVEL_WRITEBACK_CACHE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLWC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLWC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/tlwc_pkg.sv =====
package tlwc_pkg;

   localparam int ADDR_W     = 24;
   localparam int DATA_W     = 32;
   localparam int CFG_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int WORD_BYTES = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_L1_READ    = 3'd0,
      CSR_L1_WRITE   = 3'd1,
      CSR_L2_READ    = 3'd2,
      CSR_L2_WRITE   = 3'd3,
      CSR_MAIN_READ  = 3'd4,
      CSR_MAIN_WRITE = 3'd5
   } csr_index_type;

   localparam logic [CFG_W-1:0] L1_READ_RESET    = 10'd1;
   localparam logic [CFG_W-1:0] L1_WRITE_RESET   = 10'd1;
   localparam logic [CFG_W-1:0] L2_READ_RESET    = 10'd10;
   localparam logic [CFG_W-1:0] L2_WRITE_RESET   = 10'd10;
   localparam logic [CFG_W-1:0] MAIN_READ_RESET  = 10'd100;
   localparam logic [CFG_W-1:0] MAIN_WRITE_RESET = 10'd50;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_L1_TAG,
      ST_V_COPY,
      ST_L2_TAG0,
      ST_L2_TAG1,
      ST_L2_CHK,
      ST_MAIN_RD,
      ST_EVICT,
      ST_L2_WR,
      ST_L2_RD,
      ST_L2_END,
      ST_L1_FILL,
      ST_L1_ACC,
      ST_L1_RD
   } state_type;

   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_V_L1,
      CAP_F_L2,
      CAP_F_MAIN,
      CAP_MAIN_L2
   } cap_type;

endpackage

// ===== hw/rtl/tlwc_ram.sv =====
module tlwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/two_level_writeback_cache.sv =====
// Word reads and writes go through a direct-mapped write-back L1, a two-way write-back L2 with
// one replacement bit per set, and a backing store, all held in simple dual-port synchronous
// RAMs that move one word per cycle. After reset the block sweeps every RAM to zero, one entry per
// cycle, until the deepest RAM is cleared (the backing store, 262144 words at the default sizes);
// busy stays high meanwhile and configuration writes are still taken. An L1 write hit passes
// the L1 tag check and the L1 access before its result is registered, and a read hit also the
// L1 read state. Misses add the block moves, one word per cycle for each, plus the L2 tag lookup
// states ST_L2_TAG0, ST_L2_TAG1 and ST_L2_CHK per L2 access and ST_L2_END after each access:
// up to seven block moves of BLOCK_BYTES/4 words each when both levels evict dirty lines. An
// address beyond the store is answered in the cycle after acceptance with the error flag set.
// The result appears for one cycle with rsp_valid and cannot be held off by the receiver.
module two_level_writeback_cache #(
   parameter int BLOCK_BYTES = 64,
   parameter int L1_LINES    = 256,
   parameter int L2_SETS     = 256,
   parameter int MAIN_BYTES  = 1048576
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [tlwc_pkg::ADDR_W-1:0]        req_address,
   input  logic [tlwc_pkg::DATA_W-1:0]        req_write_data,
   output logic                               rsp_valid,
   output logic [tlwc_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [tlwc_pkg::DATA_W-1:0]        rsp_total_time,
   output logic                               rsp_address_error,
   input  logic                               csr_write_enable,
   input  logic [tlwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tlwc_pkg::CFG_W-1:0]         csr_write_data
);

`include "two_level_writeback_cache_defines.svh"

   localparam int WPB        = BLOCK_BYTES / tlwc_pkg::WORD_BYTES;
   localparam int WB         = $clog2(WPB);
   localparam int BO         = $clog2(BLOCK_BYTES);
   localparam int I1         = $clog2(L1_LINES);
   localparam int S2         = $clog2(L2_SETS);
   localparam int BLK_W      = tlwc_pkg::ADDR_W - BO;
   localparam int T1_W       = BLK_W - I1;
   localparam int T2_W       = BLK_W - S2;
   localparam int MAIN_WORDS = MAIN_BYTES / tlwc_pkg::WORD_BYTES;
   localparam int MW_W       = $clog2(MAIN_WORDS);
   localparam int L1D_DEPTH  = L1_LINES * WPB;
   localparam int L2D_DEPTH  = L2_SETS * 2 * WPB;
   localparam int L2T_DEPTH  = L2_SETS * 2;
   localparam int L1D_AW     = I1 + WB;
   localparam int L2D_AW     = S2 + 1 + WB;
   localparam int L2T_AW     = S2 + 1;
   localparam int CLR_MAX0   = (MAIN_WORDS > L2D_DEPTH) ? MAIN_WORDS : L2D_DEPTH;
   localparam int CLR_MAX    = (CLR_MAX0 > L1D_DEPTH) ? CLR_MAX0 : L1D_DEPTH;
   localparam int CLR_W      = $clog2(CLR_MAX);
   localparam int K_W        = BLK_W + WB + 1;

   localparam int DW = tlwc_pkg::DATA_W;

   tlwc_pkg::state_type state_ff, state_in;
   tlwc_pkg::cap_type   cap_ff, cap_in;

   logic [CLR_W-1:0]           clr_ff, clr_in;
   logic [WB-1:0]              cnt_ff, cnt_in, capidx_ff;
   logic                       cnt_last;
   logic [tlwc_pkg::CFG_W-1:0] l1r_ff, l1w_ff, l2r_ff, l2w_ff, mr_ff, mw_ff;
   logic                       cmd_ff, cmd_in;
   logic [BLK_W-1:0]           blk_ff, blk_in;
   logic [WB-1:0]              wsel_ff, wsel_in;
   logic [DW-1:0]              wdata_ff, wdata_in;
   logic                       vict1_ff, vict1_in;
   logic [T1_W-1:0]            t1tag_ff, t1tag_in;
   logic                       l2wr_ff, l2wr_in;
   logic [BLK_W-1:0]           l2blk_ff, l2blk_in;
   logic [T2_W+1:0]            way0_ff, way0_in;
   logic                       recent_ff, recent_in;
   logic                       way_ff, way_in;
   logic                       evict_ff, evict_in;
   logic [T2_W-1:0]            vtag2_ff, vtag2_in;
   logic [DW-1:0]              elapsed_ff, elapsed_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]              rsp_data_ff, rsp_data_in;
   logic [DW-1:0]              rsp_total_ff, rsp_total_in;
   logic                       rsp_err_ff, rsp_err_in;
   logic [DW-1:0]              vbuf_ff [WPB];
   logic [DW-1:0]              fbuf_ff [WPB];

   logic                       accept, out_of_range;
   logic [I1-1:0]              idx;
   logic [T1_W-1:0]            tag1;
   logic [S2-1:0]              set2;
   logic [T2_W-1:0]            tag2;
   logic                       hit0, hit1;
   logic [T2_W+1:0]            vic2;

   logic                       l1d_we, l1t_we, l2d_we, l2t_we, l2r_we, st_we;
   logic [L1D_AW-1:0]          l1d_wa, l1d_ra;
   logic [I1-1:0]              l1t_wa, l1t_ra;
   logic [L2D_AW-1:0]          l2d_wa, l2d_ra;
   logic [L2T_AW-1:0]          l2t_wa, l2t_ra;
   logic [S2-1:0]              l2r_wa, l2r_ra;
   logic [MW_W-1:0]            st_wa, st_ra;
   logic [DW-1:0]              l1d_wd, l2d_wd, st_wd;
   logic [T1_W+1:0]            l1t_wd;
   logic [T2_W+1:0]            l2t_wd;
   logic                       l2r_wd;
   logic [DW-1:0]              l1d_rd, l2d_rd, st_rd;
   logic [T1_W+1:0]            l1t_rd;
   logic [T2_W+1:0]            l2t_rd;
   logic                       l2r_rd;

   function automatic logic [MW_W-1:0] st_index(input logic [BLK_W-1:0] b,
                                                input logic [WB-1:0] i);
      logic [K_W-1:0] k;
      k = {1'b0, b, i};
      if (k >= K_W'(MAIN_WORDS)) begin
         k = k - K_W'(MAIN_WORDS);
      end
      return k[MW_W-1:0];
   endfunction

   assign accept       = start && !busy;
   assign out_of_range = {1'b0, req_address} >= (tlwc_pkg::ADDR_W + 1)'(MAIN_BYTES);
   assign cnt_last     = cnt_ff == {WB{1'b1}};
   assign idx          = blk_ff[I1-1:0];
   assign tag1         = blk_ff[BLK_W-1:I1];
   assign set2         = l2blk_ff[S2-1:0];
   assign tag2         = l2blk_ff[BLK_W-1:S2];
   assign hit0         = way0_ff[T2_W+1] && way0_ff[T2_W-1:0] == tag2;
   assign hit1         = l2t_rd[T2_W+1] && l2t_rd[T2_W-1:0] == tag2;
   assign vic2         = recent_ff ? l2t_rd : way0_ff;

   assign busy              = state_ff != tlwc_pkg::ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_total_time    = rsp_total_ff;
   assign rsp_address_error = rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1r_ff <= tlwc_pkg::L1_READ_RESET;
         l1w_ff <= tlwc_pkg::L1_WRITE_RESET;
         l2r_ff <= tlwc_pkg::L2_READ_RESET;
         l2w_ff <= tlwc_pkg::L2_WRITE_RESET;
         mr_ff  <= tlwc_pkg::MAIN_READ_RESET;
         mw_ff  <= tlwc_pkg::MAIN_WRITE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tlwc_pkg::CSR_L1_READ:    l1r_ff <= csr_write_data;
            tlwc_pkg::CSR_L1_WRITE:   l1w_ff <= csr_write_data;
            tlwc_pkg::CSR_L2_READ:    l2r_ff <= csr_write_data;
            tlwc_pkg::CSR_L2_WRITE:   l2w_ff <= csr_write_data;
            tlwc_pkg::CSR_MAIN_READ:  mr_ff  <= csr_write_data;
            tlwc_pkg::CSR_MAIN_WRITE: mw_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlwc_pkg::ST_CLEAR;
         cap_ff       <= tlwc_pkg::CAP_NONE;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      capidx_ff    <= cnt_ff;
      cmd_ff       <= cmd_in;
      blk_ff       <= blk_in;
      wsel_ff      <= wsel_in;
      wdata_ff     <= wdata_in;
      vict1_ff     <= vict1_in;
      t1tag_ff     <= t1tag_in;
      l2wr_ff      <= l2wr_in;
      l2blk_ff     <= l2blk_in;
      way0_ff      <= way0_in;
      recent_ff    <= recent_in;
      way_ff       <= way_in;
      evict_ff     <= evict_in;
      vtag2_ff     <= vtag2_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_total_ff <= rsp_total_in;
      rsp_err_ff   <= rsp_err_in;
      case (cap_ff)
         tlwc_pkg::CAP_V_L1:   vbuf_ff[capidx_ff] <= l1d_rd;
         tlwc_pkg::CAP_F_L2:   fbuf_ff[capidx_ff] <= l2d_rd;
         tlwc_pkg::CAP_F_MAIN: fbuf_ff[capidx_ff] <= st_rd;
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cap_in       = tlwc_pkg::CAP_NONE;
      clr_in       = clr_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      blk_in       = blk_ff;
      wsel_in      = wsel_ff;
      wdata_in     = wdata_ff;
      vict1_in     = vict1_ff;
      t1tag_in     = t1tag_ff;
      l2wr_in      = l2wr_ff;
      l2blk_in     = l2blk_ff;
      way0_in      = way0_ff;
      recent_in    = recent_ff;
      way_in       = way_ff;
      evict_in     = evict_ff;
      vtag2_in     = vtag2_ff;
      elapsed_in   = elapsed_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_total_in = rsp_total_ff;
      rsp_err_in   = rsp_err_ff;

      l1d_we = 1'b0;
      l1d_wa = {idx, cnt_ff};
      l1d_wd = fbuf_ff[cnt_ff];
      l1d_ra = {idx, cnt_ff};
      l1t_we = 1'b0;
      l1t_wa = idx;
      l1t_wd = {1'b1, 1'b0, tag1};
      l1t_ra = idx;
      l2d_we = 1'b0;
      l2d_wa = {set2, way_ff, cnt_ff};
      l2d_wd = l2wr_ff ? vbuf_ff[cnt_ff] : fbuf_ff[cnt_ff];
      l2d_ra = {set2, way_ff, cnt_ff};
      l2t_we = 1'b0;
      l2t_wa = {set2, way_ff};
      l2t_wd = {1'b1, l2wr_ff, tag2};
      l2t_ra = {set2, 1'b0};
      l2r_we = 1'b0;
      l2r_wa = set2;
      l2r_wd = 1'b0;
      l2r_ra = set2;
      st_we  = cap_ff == tlwc_pkg::CAP_MAIN_L2;
      st_wa  = st_index({vtag2_ff, set2}, capidx_ff);
      st_wd  = l2d_rd;
      st_ra  = st_index(l2blk_ff, cnt_ff);

      unique case (state_ff)
         tlwc_pkg::ST_CLEAR: begin
            l1d_we = {1'b0, clr_ff} < (CLR_W + 1)'(L1D_DEPTH);
            l1d_wa = clr_ff[L1D_AW-1:0];
            l1d_wd = '0;
            l1t_we = {1'b0, clr_ff} < (CLR_W + 1)'(L1_LINES);
            l1t_wa = clr_ff[I1-1:0];
            l1t_wd = '0;
            l2d_we = {1'b0, clr_ff} < (CLR_W + 1)'(L2D_DEPTH);
            l2d_wa = clr_ff[L2D_AW-1:0];
            l2d_wd = '0;
            l2t_we = {1'b0, clr_ff} < (CLR_W + 1)'(L2T_DEPTH);
            l2t_wa = clr_ff[L2T_AW-1:0];
            l2t_wd = '0;
            l2r_we = {1'b0, clr_ff} < (CLR_W + 1)'(L2_SETS);
            l2r_wa = clr_ff[S2-1:0];
            st_we  = {1'b0, clr_ff} < (CLR_W + 1)'(MAIN_WORDS);
            st_wa  = clr_ff[MW_W-1:0];
            st_wd  = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(CLR_MAX - 1)) begin
               state_in = tlwc_pkg::ST_IDLE;
            end
         end
         tlwc_pkg::ST_IDLE: begin
            l1t_ra = req_address[BO+I1-1:BO];
            if (start) begin
               cmd_in   = req_cmd;
               blk_in   = req_address[tlwc_pkg::ADDR_W-1:BO];
               wsel_in  = req_address[BO-1:2];
               wdata_in = req_write_data;
               if (out_of_range) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_total_in = elapsed_ff;
                  rsp_err_in   = 1'b1;
               end else begin
                  state_in = tlwc_pkg::ST_L1_TAG;
               end
            end
         end
         tlwc_pkg::ST_L1_TAG: begin
            vict1_in = l1t_rd[T1_W+1] && l1t_rd[T1_W];
            t1tag_in = l1t_rd[T1_W-1:0];
            l2wr_in  = 1'b0;
            l2blk_in = blk_ff;
            if (l1t_rd[T1_W+1] && l1t_rd[T1_W-1:0] == tag1) begin
               state_in = tlwc_pkg::ST_L1_ACC;
            end else if (l1t_rd[T1_W+1] && l1t_rd[T1_W]) begin
               state_in = tlwc_pkg::ST_V_COPY;
            end else begin
               state_in = tlwc_pkg::ST_L2_TAG0;
            end
         end
         tlwc_pkg::ST_V_COPY: begin
            cap_in = tlwc_pkg::CAP_V_L1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = tlwc_pkg::ST_L2_TAG0;
            end
         end
         tlwc_pkg::ST_L2_TAG0: begin
            state_in = tlwc_pkg::ST_L2_TAG1;
         end
         tlwc_pkg::ST_L2_TAG1: begin
            l2t_ra    = {set2, 1'b1};
            way0_in   = l2t_rd;
            recent_in = l2r_rd;
            state_in  = tlwc_pkg::ST_L2_CHK;
         end
         tlwc_pkg::ST_L2_CHK: begin
            if (hit0 || hit1) begin
               way_in     = !hit0;
               l2t_we     = l2wr_ff;
               l2t_wa     = {set2, !hit0};
               l2t_wd     = {1'b1, 1'b1, tag2};
               l2r_we     = 1'b1;
               l2r_wd     = hit0;
               elapsed_in = elapsed_ff + DW'(l2wr_ff ? l2w_ff : l2r_ff);
               state_in   = l2wr_ff ? tlwc_pkg::ST_L2_WR : tlwc_pkg::ST_L2_RD;
            end else begin
               way_in     = recent_ff;
               evict_in   = vic2[T2_W+1] && vic2[T2_W];
               vtag2_in   = vic2[T2_W-1:0];
               l2t_we     = 1'b1;
               l2t_wa     = {set2, recent_ff};
               l2r_we     = 1'b1;
               l2r_wd     = !recent_ff;
               elapsed_in = elapsed_ff + DW'(mr_ff)
                          + ((vic2[T2_W+1] && vic2[T2_W]) ? DW'(mw_ff) : '0)
                          + DW'(l2wr_ff ? l2w_ff : l2r_ff);
               if (!l2wr_ff) begin
                  state_in = tlwc_pkg::ST_MAIN_RD;
               end else if (vic2[T2_W+1] && vic2[T2_W]) begin
                  state_in = tlwc_pkg::ST_EVICT;
               end else begin
                  state_in = tlwc_pkg::ST_L2_WR;
               end
            end
         end
         tlwc_pkg::ST_MAIN_RD: begin
            cap_in = tlwc_pkg::CAP_F_MAIN;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = evict_ff ? tlwc_pkg::ST_EVICT : tlwc_pkg::ST_L2_WR;
            end
         end
         tlwc_pkg::ST_EVICT: begin
            cap_in = tlwc_pkg::CAP_MAIN_L2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = tlwc_pkg::ST_L2_WR;
            end
         end
         tlwc_pkg::ST_L2_WR: begin
            l2d_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = tlwc_pkg::ST_L2_END;
            end
         end
         tlwc_pkg::ST_L2_RD: begin
            cap_in = tlwc_pkg::CAP_F_L2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = tlwc_pkg::ST_L2_END;
            end
         end
         tlwc_pkg::ST_L2_END: begin
            if (!l2wr_ff && vict1_ff) begin
               l2wr_in  = 1'b1;
               l2blk_in = {t1tag_ff, idx};
               state_in = tlwc_pkg::ST_L2_TAG0;
            end else begin
               state_in = tlwc_pkg::ST_L1_FILL;
            end
         end
         tlwc_pkg::ST_L1_FILL: begin
            l1d_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               l1t_we   = 1'b1;
               state_in = tlwc_pkg::ST_L1_ACC;
            end
         end
         tlwc_pkg::ST_L1_ACC: begin
            l1d_ra = {idx, wsel_ff};
            if (cmd_ff) begin
               l1d_we       = 1'b1;
               l1d_wa       = {idx, wsel_ff};
               l1d_wd       = wdata_ff;
               l1t_we       = 1'b1;
               l1t_wd       = {1'b1, 1'b1, tag1};
               elapsed_in   = elapsed_ff + DW'(l1w_ff);
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_total_in = elapsed_ff + DW'(l1w_ff);
               rsp_err_in   = 1'b0;
               state_in     = tlwc_pkg::ST_IDLE;
            end else begin
               elapsed_in = elapsed_ff + DW'(l1r_ff);
               state_in   = tlwc_pkg::ST_L1_RD;
            end
         end
         tlwc_pkg::ST_L1_RD: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = l1d_rd;
            rsp_total_in = elapsed_ff;
            rsp_err_in   = 1'b0;
            state_in     = tlwc_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlwc_pkg::ST_IDLE;
         end
      endcase
   end

   tlwc_ram #(.WIDTH(DW), .DEPTH(L1D_DEPTH)) u_l1_data (
      .clock(clock), .we(l1d_we), .waddr(l1d_wa), .wdata(l1d_wd),
      .raddr(l1d_ra), .rdata(l1d_rd)
   );

   tlwc_ram #(.WIDTH(T1_W + 2), .DEPTH(L1_LINES)) u_l1_tag (
      .clock(clock), .we(l1t_we), .waddr(l1t_wa), .wdata(l1t_wd),
      .raddr(l1t_ra), .rdata(l1t_rd)
   );

   tlwc_ram #(.WIDTH(DW), .DEPTH(L2D_DEPTH)) u_l2_data (
      .clock(clock), .we(l2d_we), .waddr(l2d_wa), .wdata(l2d_wd),
      .raddr(l2d_ra), .rdata(l2d_rd)
   );

   tlwc_ram #(.WIDTH(T2_W + 2), .DEPTH(L2T_DEPTH)) u_l2_tag (
      .clock(clock), .we(l2t_we), .waddr(l2t_wa), .wdata(l2t_wd),
      .raddr(l2t_ra), .rdata(l2t_rd)
   );

   tlwc_ram #(.WIDTH(1), .DEPTH(L2_SETS)) u_l2_recent (
      .clock(clock), .we(l2r_we), .waddr(l2r_wa), .wdata(l2r_wd),
      .raddr(l2r_ra), .rdata(l2r_rd)
   );

   tlwc_ram #(.WIDTH(DW), .DEPTH(MAIN_WORDS)) u_main (
      .clock(clock), .we(st_we), .waddr(st_wa), .wdata(st_wd),
      .raddr(st_ra), .rdata(st_rd)
   );

   `TLWC_ASSERT_NEXT(a_range_rsp, accept && out_of_range, rsp_valid && rsp_address_error)
   `TLWC_ASSERT_NEXT(a_write_rsp, state_ff == tlwc_pkg::ST_L1_ACC && cmd_ff, rsp_valid && rsp_read_data == '0)
   `TLWC_ASSERT_NOW(a_evict_src, cap_ff == tlwc_pkg::CAP_MAIN_L2, evict_ff)

endmodule
